// File: src/tme_pkg.sv
// Shared types, constants and helpers for the triangular membership evaluator.
// No dependencies; the divider and the top level import this package.
`default_nettype none

package tme_pkg;

  // Default number of fraction bits of the coordinate format (Q3.13).
  localparam int COORD_FRAC_BITS_DEF = 13;

  // Full clip height and membership of one in Q1.15.
  localparam int H_ONE = 32768;

  // Width of the internal centroid arithmetic.
  localparam int WW = 44;

  // Membership divider: quotient bits, bits per stage, stage count.
  localparam int DIV_QB     = 15;
  localparam int DIV_SPS    = 4;
  localparam int DIV_STAGES = (DIV_QB + DIV_SPS - 1) / DIV_SPS;

  // Reciprocals for the divide-by-constant units, scaled by 2^24.
  localparam int RECIP_SHIFT = 24;
  localparam logic [22:0] RECIP3 = 23'(((64'd1 << RECIP_SHIFT)) / 3);
  localparam logic [22:0] RECIP9 = 23'(((64'd1 << RECIP_SHIFT)) / 9);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT = 2'd2;

  // Register reset values.
  localparam logic signed [15:0] LEFT_RST  = -16'sd8192;
  localparam logic signed [15:0] PEAK_RST  = 16'sd0;
  localparam logic signed [15:0] RIGHT_RST = 16'sd8192;

  // How the membership of a sample is formed.
  typedef enum logic [1:0] {
    MC_ZERO = 2'd0,
    MC_ONE  = 2'd1,
    MC_DIV  = 2'd2
  } mcase_t;

  // Which centroid formula applies.
  typedef enum logic [1:0] {
    CC_GEN = 2'd0,
    CC_SHR = 2'd1,
    CC_SHL = 2'd2
  } ccase_t;

  // Magnitude of a difference of two 16-bit coordinates.
  function automatic logic [16:0] abs17(input logic signed [16:0] v);
    return (v < 0) ? 17'(-v) : 17'(v);
  endfunction

  // Magnitude of a wide centroid term.
  function automatic logic signed [WW-1:0] absw(input logic signed [WW-1:0] v);
    return (v < 0) ? -v : v;
  endfunction

endpackage

`default_nettype wire

// File: src/tme_if.sv
// Request channel interfaces of the triangular membership evaluator.
// Depends on nothing; used by the top level.
`default_nettype none

interface tme_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_x;
  logic        [15:0] clip_height;

  modport source (output valid, sample_x, clip_height, input ready);
  modport sink   (input valid, sample_x, clip_height, output ready);
endinterface

interface tme_out_if;
  logic               valid;
  logic               ready;
  logic        [15:0] membership;
  logic        [14:0] clipped_area;
  logic signed [15:0] centroid_x;
  logic        [15:0] centroid_y;

  modport source (output valid, membership, clipped_area, centroid_x, centroid_y,
                  input ready);
  modport sink   (input valid, membership, clipped_area, centroid_x, centroid_y,
                  output ready);
endinterface

`default_nettype wire

// File: src/tme_div.sv
// Pipelined restoring divider for the membership slope, DIV_SPS bits a stage.
// Depends on tme_pkg; the numerator is always below the divisor.
`default_nettype none

module tme_div import tme_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [15:0]       num,
  input  logic [15:0]       den,
  output logic [DIV_QB-1:0] quo
);

  logic [15:0]       rem_r [DIV_STAGES];
  logic [15:0]       den_r [DIV_STAGES];
  logic [DIV_QB-1:0] quo_r [DIV_STAGES];
  logic [15:0]       rem_nxt [DIV_STAGES];
  logic [DIV_QB-1:0] quo_nxt [DIV_STAGES];
  logic [15:0]       den_in  [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    // Each stage shifts in up to DIV_SPS quotient bits, one compare and subtract each.
    if (g == 0) begin : g_first
      always_comb begin
        logic [15:0]       rem;
        logic [16:0]       r2;
        logic [DIV_QB-1:0] q;
        rem = num;
        q   = '0;
        for (int j = 0; j < DIV_SPS; j++) begin
          if (j < DIV_QB) begin
            r2 = {rem, 1'b0};
            if (r2 >= {1'b0, den}) begin
              rem = 16'(r2 - {1'b0, den});
              q   = {q[DIV_QB-2:0], 1'b1};
            end else begin
              rem = r2[15:0];
              q   = {q[DIV_QB-2:0], 1'b0};
            end
          end
        end
        rem_nxt[g] = rem;
        quo_nxt[g] = q;
        den_in[g]  = den;
      end
    end else begin : g_next
      always_comb begin
        logic [15:0]       rem;
        logic [16:0]       r2;
        logic [DIV_QB-1:0] q;
        rem = rem_r[g-1];
        q   = quo_r[g-1];
        for (int j = 0; j < DIV_SPS; j++) begin
          if (g * DIV_SPS + j < DIV_QB) begin
            r2 = {rem, 1'b0};
            if (r2 >= {1'b0, den_r[g-1]}) begin
              rem = 16'(r2 - {1'b0, den_r[g-1]});
              q   = {q[DIV_QB-2:0], 1'b1};
            end else begin
              rem = r2[15:0];
              q   = {q[DIV_QB-2:0], 1'b0};
            end
          end
        end
        rem_nxt[g] = rem;
        quo_nxt[g] = q;
        den_in[g]  = den_r[g-1];
      end
    end

    // Stage registers advance with the main pipeline.
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= rem_nxt[g];
        quo_r[g] <= quo_nxt[g];
        den_r[g] <= den_in[g];
      end
    end
  end

  assign quo = quo_r[DIV_STAGES-1];

endmodule

`default_nettype wire

// File: src/triangular_membership_eval.sv
// Triangular fuzzy membership evaluator: membership, clipped area and centroid.
// Throughput: one request per cycle while the output is not stalled; the nine-stage
// pipeline, with a four-stage slope divider and a pipelined divide-by-constant for
// the centroid, sets that figure. A stalled output freezes the whole pipeline.
// Reset (synchronous, active low) empties the pipeline and returns the three points
// to -1, 0 and +1.
`default_nettype none

module triangular_membership_eval import tme_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tme_in_if.sink               in_ch,
  tme_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [15:0]          cfg_wdata
);

  localparam int NST = 9;
  localparam logic signed [33:0]   ONE_C = 34'sd1 <<< COORD_FRAC_BITS;
  localparam logic signed [33:0]   ONE21 = ONE_C * 34'sd21;
  localparam logic signed [WW-1:0] ONE_W = WW'(ONE_C);

  typedef struct packed {
    logic [15:0]             h;
    logic [15:0]             s;
    mcase_t                  mcase;
    logic [15:0]             num;
    logic [15:0]             den;
    logic signed [16:0]      base;
    ccase_t                  ccase;
    logic                    sel_a;
    logic [31:0]             ss;
    logic signed [33:0]      half;
    logic signed [33:0]      sm;
    logic [30:0]             t;
    logic signed [48:0]      prod;
    logic signed [WW-1:0]    c1;
    logic signed [WW-1:0]    lo;
    logic signed [WW-1:0]    hi;
    logic signed [WW-1:0]    tl;
    logic signed [WW-1:0]    tr;
    logic signed [WW-1:0]    nsum;
    logic [14:0]             area;
    logic [15:0]             mem;
    logic [19:0]             mo;
    logic [19:0]             ny;
    logic                    d9;
    logic                    dy9;
    logic [19:0]             q0;
    logic [19:0]             qy0;
    logic [15:0]             cx;
    logic [15:0]             cy;
  } ctx_t;

  // Configuration registers.
  logic signed [15:0] left_r, peak_r, right_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= LEFT_RST;
      peak_r  <= PEAK_RST;
      right_r <= RIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_LEFT:  left_r  <= cfg_wdata;
        REG_PEAK:  peak_r  <= cfg_wdata;
        REG_RIGHT: right_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline control: everything advances unless the output is held.
  logic           adv, in_acc;
  logic [NST-1:0] v_r;
  ctx_t           pipe_r [NST];
  ctx_t           p0_nxt, p1_nxt, p2_nxt, p3_nxt, p4_nxt, p5_nxt, p6_nxt, p7_nxt, p8_nxt;
  logic [DIV_QB-1:0] quo;

  assign adv         = !v_r[NST-1] || out_ch.ready;
  assign in_ch.ready = adv;
  assign in_acc      = in_ch.valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NST-2:0], in_acc};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe_r[0] <= p0_nxt;
      pipe_r[1] <= p1_nxt;
      pipe_r[2] <= p2_nxt;
      pipe_r[3] <= p3_nxt;
      pipe_r[4] <= p4_nxt;
      pipe_r[5] <= p5_nxt;
      pipe_r[6] <= p6_nxt;
      pipe_r[7] <= p7_nxt;
      pipe_r[8] <= p8_nxt;
    end
  end

  // Extended copies of the points and the sample.
  logic signed [16:0] xe, x1e, x2e, x3e;
  logic signed [33:0] x1w, x3w;
  logic signed [WW-1:0] x1ww, x2ww, x3ww;
  assign xe   = 17'(in_ch.sample_x);
  assign x1e  = 17'(left_r);
  assign x2e  = 17'(peak_r);
  assign x3e  = 17'(right_r);
  assign x1w  = 34'(left_r);
  assign x3w  = 34'(right_r);
  assign x1ww = WW'(left_r);
  assign x2ww = WW'(peak_r);
  assign x3ww = WW'(right_r);

  // Stage 0: clamp the height, classify the sample and the triangle.
  always_comb begin
    logic signed [16:0] den_l, num_l, den_r, num_r;
    den_l  = x2e - x1e;
    num_l  = x2e - xe;
    den_r  = x3e - x2e;
    num_r  = xe - x2e;
    p0_nxt = '0;
    p0_nxt.h = (in_ch.clip_height > 16'(H_ONE)) ? 16'(H_ONE) : in_ch.clip_height;
    p0_nxt.s = 16'(17'(H_ONE) - {1'b0, p0_nxt.h});
    p0_nxt.mcase = MC_ZERO;
    p0_nxt.num = 16'd0;
    p0_nxt.den = 16'd1;
    if (xe > x1e && xe < x2e) begin
      p0_nxt.mcase = MC_DIV;
      p0_nxt.num   = num_l[15:0];
      p0_nxt.den   = den_l[15:0];
    end else if (xe >= x2e && xe <= x3e) begin
      if (den_r == 17'sd0) begin
        p0_nxt.mcase = MC_ONE;
      end else if (num_r == den_r) begin
        p0_nxt.mcase = MC_ZERO;
      end else begin
        p0_nxt.mcase = MC_DIV;
        p0_nxt.num   = num_r[15:0];
        p0_nxt.den   = den_r[15:0];
      end
    end
    // Base of the area: shoulder triangles keep only their inner half.
    if (x3w > ONE_C) begin
      p0_nxt.base = x2e - x1e;
    end else if (x1w < -ONE_C) begin
      p0_nxt.base = x3e - x2e;
    end else begin
      p0_nxt.base = x3e - x1e;
    end
    if (x3w * 34'sd20 > ONE21) begin
      p0_nxt.ccase = CC_SHR;
    end else if (x1w * 34'sd20 < -ONE21) begin
      p0_nxt.ccase = CC_SHL;
    end else begin
      p0_nxt.ccase = CC_GEN;
    end
    p0_nxt.sel_a = abs17(x2e - x1e) > abs17(x3e - x2e);
  end

  // Stage 1: products with the unclipped height.
  always_comb begin
    logic signed [16:0] sv, ab;
    p1_nxt = pipe_r[0];
    sv = $signed({1'b0, pipe_r[0].s});
    ab = pipe_r[0].sel_a ? (x2e - x1e) : (x3e - x2e);
    p1_nxt.ss   = pipe_r[0].s * pipe_r[0].s;
    p1_nxt.half = sv * (x3e - x1e);
    p1_nxt.sm   = sv * ab;
  end

  // Stage 2: area height term and the clip centre.
  always_comb begin
    logic signed [WW-1:0] x2s, sm2, hw;
    p2_nxt = pipe_r[1];
    x2s = x2ww <<< 16;
    sm2 = WW'(pipe_r[1].sm) <<< 1;
    hw  = WW'(pipe_r[1].half);
    p2_nxt.t  = 31'(32'd1073741824 - pipe_r[1].ss);
    p2_nxt.c1 = pipe_r[1].sel_a ? (x2s - sm2 + hw) : (x2s + sm2 - hw);
  end

  // Stage 3: area product and the ends of the clip segment.
  always_comb begin
    logic signed [WW-1:0] hw;
    p3_nxt = pipe_r[2];
    hw = WW'(pipe_r[2].half);
    p3_nxt.prod = pipe_r[2].base * $signed({1'b0, pipe_r[2].t});
    p3_nxt.lo   = pipe_r[2].c1 - hw;
    p3_nxt.hi   = pipe_r[2].c1 + hw;
  end

  // Stage 4: scaled area and the side triangle centroids.
  always_comb begin
    logic signed [WW-1:0] x1s, x3s, lo, hi;
    p4_nxt = pipe_r[3];
    x1s = x1ww <<< 16;
    x3s = x3ww <<< 16;
    lo  = pipe_r[3].lo;
    hi  = pipe_r[3].hi;
    if (pipe_r[3].prod <= 49'sd0) begin
      p4_nxt.area = 15'd0;
    end else if (pipe_r[3].prod[47:31] > 17'd32767) begin
      p4_nxt.area = 15'h7fff;
    end else begin
      p4_nxt.area = pipe_r[3].prod[45:31];
    end
    p4_nxt.tl = (lo <<< 1) + lo - absw(x1s - lo);
    p4_nxt.tr = (hi <<< 1) + hi + absw(x3s - hi);
  end

  // Membership slope division.
  tme_div u_div (
    .clk (clk),
    .en  (adv),
    .num (pipe_r[0].num),
    .den (pipe_r[0].den),
    .quo (quo)
  );

  // Stage 5: membership and the centroid numerator.
  always_comb begin
    logic signed [WW-1:0] c1;
    p5_nxt = pipe_r[4];
    c1 = pipe_r[4].c1;
    case (pipe_r[4].mcase)
      MC_DIV:  p5_nxt.mem = 16'(17'(H_ONE) - {2'b00, quo});
      MC_ONE:  p5_nxt.mem = 16'(H_ONE);
      default: p5_nxt.mem = 16'd0;
    endcase
    case (pipe_r[4].ccase)
      CC_SHR:  p5_nxt.nsum = (x2ww <<< 1) + x2ww - absw(x1ww - ONE_W);
      CC_SHL:  p5_nxt.nsum = (x2ww <<< 1) + x2ww + absw(x3ww + ONE_W);
      default: begin
        if (pipe_r[4].h == 16'(H_ONE)) begin
          p5_nxt.nsum = pipe_r[4].tl + pipe_r[4].tr;
        end else begin
          p5_nxt.nsum = (c1 <<< 1) + c1 + pipe_r[4].tl + pipe_r[4].tr;
        end
      end
    endcase
  end

  // Stage 6: rounding offset, pre-scale, clamp and bias to a positive dividend.
  always_comb begin
    logic signed [WW-1:0] m, lim_lo, lim_hi, off;
    logic                 plain;
    p6_nxt = pipe_r[5];
    plain  = (pipe_r[5].ccase != CC_GEN) || (pipe_r[5].h == 16'(H_ONE));
    if (pipe_r[5].ccase != CC_GEN) begin
      m = pipe_r[5].nsum + WW'(1);
      p6_nxt.d9 = 1'b0;
    end else if (pipe_r[5].h == 16'(H_ONE)) begin
      m = (pipe_r[5].nsum + WW'(196608)) >>> 17;
      p6_nxt.d9 = 1'b0;
    end else begin
      m = (pipe_r[5].nsum + WW'(294912)) >>> 16;
      p6_nxt.d9 = 1'b1;
    end
    lim_lo = p6_nxt.d9 ? -WW'(294912) : -WW'(98304);
    lim_hi = p6_nxt.d9 ? WW'(294911) : WW'(98303);
    off    = p6_nxt.d9 ? WW'(294912) : WW'(98304);
    if (m < lim_lo) begin
      m = lim_lo;
    end else if (m > lim_hi) begin
      m = lim_hi;
    end
    p6_nxt.mo  = 20'(m + off);
    p6_nxt.dy9 = !plain;
    if (plain) begin
      p6_nxt.ny = 20'({4'd0, pipe_r[5].h} + 20'd1);
    end else begin
      p6_nxt.ny = 20'((20'd7 * {4'd0, pipe_r[5].h} + 20'd9) >> 1);
    end
  end

  // Stage 7: reciprocal estimates of both quotients.
  always_comb begin
    logic [42:0] px, py;
    p7_nxt = pipe_r[6];
    px = pipe_r[6].mo * (pipe_r[6].d9 ? RECIP9 : RECIP3);
    py = pipe_r[6].ny * (pipe_r[6].dy9 ? RECIP9 : RECIP3);
    p7_nxt.q0  = {1'b0, px[42:RECIP_SHIFT]};
    p7_nxt.qy0 = {1'b0, py[42:RECIP_SHIFT]};
  end

  // Stage 8: one correction step, then remove the bias.
  always_comb begin
    logic [19:0] rx, ry, qx, qy, dx, dy;
    p8_nxt = pipe_r[7];
    dx = pipe_r[7].d9 ? 20'd9 : 20'd3;
    dy = pipe_r[7].dy9 ? 20'd9 : 20'd3;
    rx = pipe_r[7].mo - 20'(pipe_r[7].q0 * dx);
    ry = pipe_r[7].ny - 20'(pipe_r[7].qy0 * dy);
    qx = (rx >= dx) ? pipe_r[7].q0 + 20'd1 : pipe_r[7].q0;
    qy = (ry >= dy) ? pipe_r[7].qy0 + 20'd1 : pipe_r[7].qy0;
    p8_nxt.cx = qx[15:0] ^ 16'h8000;
    p8_nxt.cy = qy[15:0];
  end

  // Output register.
  assign out_ch.valid        = v_r[NST-1];
  assign out_ch.membership   = pipe_r[8].mem;
  assign out_ch.clipped_area = pipe_r[8].area;
  assign out_ch.centroid_x   = $signed(pipe_r[8].cx);
  assign out_ch.centroid_y   = pipe_r[8].cy;

  // Checks on the pipeline.
  a_mem_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.membership <= 16'd32768)
    else $error("membership above one");

  a_cy_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.centroid_y <= 16'd12743)
    else $error("centroid y above its bound");

  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> $past(v_r[NST-2] && adv) || $past(out_ch.valid && !adv))
    else $error("result appeared without a request behind it");

endmodule

`default_nettype wire
